@@ rtl/core/lgni_pkg.sv @@
// Package for the layered grid neighbour indexer.
// Holds widths, register indexes and shared types; no dependencies.
`default_nettype none
package lgni_pkg;
   localparam int CoordW = 10;
   localparam int SizeW = 11;
   localparam int LayerW = 10;
   localparam int IdxW = 30;
   localparam int CsrW = 11;
   localparam int CsrAddrW = 3;
   localparam int NbrMax = 9;
   localparam int CntW = 4;

   localparam logic [CsrAddrW-1:0] REG_SIZE_X = 3'd0;
   localparam logic [CsrAddrW-1:0] REG_SIZE_Y = 3'd1;
   localparam logic [CsrAddrW-1:0] REG_SIZE_Z = 3'd2;
   localparam logic [CsrAddrW-1:0] REG_HEX = 3'd3;
   localparam logic [CsrAddrW-1:0] REG_PRISM = 3'd4;

   typedef struct packed {
      logic [SizeW-1:0] size_x;
      logic [SizeW-1:0] size_y;
      logic [SizeW-1:0] size_z;
      logic [LayerW-1:0] hex_layers;
      logic [LayerW-1:0] prism_layers;
   } cfg_type;

   typedef logic [NbrMax-1:0][IdxW-1:0] idx_list_type;
endpackage
`default_nettype wire

@@ rtl/core/layered_grid_neighbour_indexer.sv @@
// Top level of the layered grid neighbour indexer.
// Uses lgni_pkg, lgni_mod and lgni_sort.
//
//  channel | ports                                   | role
//  req     | req_valid req_stall req_coord_x/y/z     | node coordinate in
//  rsp     | rsp_valid rsp_stall rsp_node_index/last | sorted indices out
//  csr     | csr_write csr_index csr_data            | grid registers
//
// Item pipeline: 11 phase stages (load, then 10 quotient bits), 2 index stages
// (multiply, add), 1 classify, 10 sort stages (load, then 9 passes), then an
// output queue. Each node yields 1 to 9 transfers, one per cycle while rsp_stall
// is low, so the output port sets the node rate. Reset clears valid bits and
// loads register defaults. The pipeline advances whenever the output queue has
// room for a whole node; a stall holds everything.
`default_nettype none
module layered_grid_neighbour_indexer (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_write,
   input wire logic [lgni_pkg::CsrAddrW-1:0] csr_index,
   input wire logic [lgni_pkg::CsrW-1:0] csr_data,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [lgni_pkg::CoordW-1:0] req_coord_x,
   input wire logic [lgni_pkg::CoordW-1:0] req_coord_y,
   input wire logic [lgni_pkg::CoordW-1:0] req_coord_z,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [lgni_pkg::IdxW-1:0] rsp_node_index,
   output logic rsp_last
);
   import lgni_pkg::*;
   localparam int ModD = CoordW + 1;
   localparam int QDepth = 16;
   localparam int QAw = 4;

   cfg_type cfg_ff;
   logic advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_x <= SizeW'(2);
         cfg_ff.size_y <= SizeW'(2);
         cfg_ff.size_z <= SizeW'(2);
         cfg_ff.hex_layers <= LayerW'(1);
         cfg_ff.prism_layers <= LayerW'(1);
      end else if (csr_write) begin
         case (csr_index)
            REG_SIZE_X: cfg_ff.size_x <= csr_data;
            REG_SIZE_Y: cfg_ff.size_y <= csr_data;
            REG_SIZE_Z: cfg_ff.size_z <= csr_data;
            REG_HEX: cfg_ff.hex_layers <= csr_data[LayerW-1:0];
            REG_PRISM: cfg_ff.prism_layers <= csr_data[LayerW-1:0];
            default: ;
         endcase
      end
   end

   // front delay line alongside the phase unit
   logic [ModD-1:0] vld_ff;
   logic [ModD-1:0][CoordW-1:0] x_ff, y_ff, z_ff;
   logic [SizeW-1:0] m_w;

   lgni_mod u_mod (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(req_valid),
      .in_z(req_coord_z),
      .in_period(SizeW'(cfg_ff.hex_layers) + SizeW'(cfg_ff.prism_layers)),
      .out_rem(m_w)
   );

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[ModD-2:0], req_valid};
      if (advance) begin
         x_ff[0] <= req_coord_x;
         y_ff[0] <= req_coord_y;
         z_ff[0] <= req_coord_z;
         for (int s = 1; s < ModD; s++) begin
            x_ff[s] <= x_ff[s-1];
            y_ff[s] <= y_ff[s-1];
            z_ff[s] <= z_ff[s-1];
         end
      end
   end

   // stage A: products
   logic a_vld_ff;
   logic [CoordW-1:0] ax_ff, ay_ff, az_ff;
   logic [SizeW-1:0] am_ff;
   logic [2*SizeW-1:0] sxy_ff;
   logic [SizeW+CoordW:0] ylin_ff;
   logic [2*SizeW-1:0] sxy_w;
   assign sxy_w = cfg_ff.size_x * cfg_ff.size_y;

   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else if (advance) a_vld_ff <= vld_ff[ModD-1];
      if (advance) begin
         ax_ff <= x_ff[ModD-1];
         ay_ff <= y_ff[ModD-1];
         az_ff <= z_ff[ModD-1];
         am_ff <= m_w;
         sxy_ff <= sxy_w;
         ylin_ff <= (SizeW+CoordW+1)'(y_ff[ModD-1] * cfg_ff.size_x);
      end
   end

   // stage B: base index and z stride
   logic b_vld_ff;
   logic [CoordW-1:0] bx_ff, by_ff, bz_ff;
   logic [SizeW-1:0] bm_ff;
   logic [IdxW-1:0] base_ff, sxy30_ff;
   logic [IdxW-1:0] zprod_w;
   assign zprod_w = IdxW'(az_ff * sxy_ff);

   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else if (advance) b_vld_ff <= a_vld_ff;
      if (advance) begin
         bx_ff <= ax_ff;
         by_ff <= ay_ff;
         bz_ff <= az_ff;
         bm_ff <= am_ff;
         sxy30_ff <= IdxW'(sxy_ff);
         base_ff <= zprod_w + IdxW'(ylin_ff) + IdxW'(ax_ff);
      end
   end

   // stage C: neighbour list and classification
   idx_list_type list_w;
   logic [NbrMax-1:0] keep_w;
   always_comb begin
      logic [SizeW:0] x1, y1, z1, m0, sx, sy, sz, hx;
      logic xlo, xhi, ylo, yhi, zlo, zhi, hex, lo_ok, hi_ok;
      x1 = {2'b0, bx_ff};
      y1 = {2'b0, by_ff};
      z1 = {2'b0, bz_ff};
      m0 = {1'b0, bm_ff};
      sx = {1'b0, cfg_ff.size_x};
      sy = {1'b0, cfg_ff.size_y};
      sz = {1'b0, cfg_ff.size_z};
      hx = {2'b0, cfg_ff.hex_layers};
      yhi = y1 < sy && z1 < sz;
      xhi = x1 + 1 < sx && yhi;
      xlo = x1 != 0 && x1 - 1 < sx && yhi;
      ylo = by_ff != '0 && x1 < sx && y1 - 1 < sy && z1 < sz;
      yhi = x1 < sx && y1 + 1 < sy && z1 < sz;
      zhi = x1 < sx && y1 < sy && z1 + 1 < sz;
      zlo = bz_ff != '0 && x1 < sx && y1 < sy && z1 - 1 < sz;
      hex = bz_ff == '0 || (m0 == 0 && bx_ff == '0)
         || (m0 == 1 && sx != 0 && x1 == sx - 1)
         || (hx > 1 && m0 != 0 && m0 < hx);
      lo_ok = bx_ff != '0 && bz_ff != '0 && x1 - 1 < sx && z1 - 1 < sz;
      hi_ok = x1 + 1 < sx && z1 + 1 < sz;
      list_w[0] = base_ff;
      list_w[1] = base_ff + 1'b1;
      list_w[2] = base_ff - 1'b1;
      list_w[3] = base_ff + IdxW'(cfg_ff.size_x);
      list_w[4] = base_ff - IdxW'(cfg_ff.size_x);
      list_w[5] = base_ff + sxy30_ff;
      list_w[6] = base_ff - sxy30_ff;
      list_w[7] = base_ff + sxy30_ff + 1'b1;
      list_w[8] = base_ff - sxy30_ff - 1'b1;
      keep_w = {lo_ok, hi_ok, zlo, zhi, ylo, yhi, xlo, xhi, 1'b1};
      if (hex) keep_w[8:7] = 2'b00;
      else if (m0 == 0 && lo_ok) keep_w[8:7] = 2'b10;
      else if (m0 == hx && hi_ok) keep_w[8:7] = 2'b01;
   end

   logic c_vld_ff;
   idx_list_type c_list_ff;
   logic [NbrMax-1:0] c_keep_ff;
   always_ff @(posedge clock) begin
      if (reset) c_vld_ff <= 1'b0;
      else if (advance) c_vld_ff <= b_vld_ff;
      if (advance) begin
         c_list_ff <= list_w;
         c_keep_ff <= keep_w;
      end
   end

   logic s_vld;
   idx_list_type s_list;
   logic [NbrMax-1:0] s_keep;
   lgni_sort u_sort (
      .clock(clock), .reset(reset), .advance(advance), .in_valid(c_vld_ff),
      .in_list(c_list_ff), .in_keep(c_keep_ff),
      .out_valid(s_vld), .out_list(s_list), .out_keep(s_keep)
   );

   // output queue: a node writes up to nine entries in one cycle
   logic [IdxW:0] q_mem [QDepth];
   logic [QAw-1:0] rd_ff, wr_ff;
   logic [QAw:0] cnt_ff;
   logic [CntW-1:0] n_w;
   logic pop;

   always_comb begin
      n_w = '0;
      for (int i = 0; i < NbrMax; i++) n_w = n_w + CntW'(s_keep[i]);
   end

   assign pop = rsp_valid && !rsp_stall;
   assign advance = (QDepth - NbrMax) >= int'(cnt_ff);
   assign req_stall = !advance;
   assign rsp_valid = cnt_ff != '0;
   assign rsp_node_index = q_mem[rd_ff][IdxW-1:0];
   assign rsp_last = q_mem[rd_ff][IdxW];

   always_ff @(posedge clock) begin
      logic [QAw:0] add;
      add = (advance && s_vld) ? (QAw+1)'(n_w) : '0;
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (pop) rd_ff <= rd_ff + 1'b1;
         wr_ff <= wr_ff + add[QAw-1:0];
         cnt_ff <= cnt_ff + add - (QAw+1)'(pop);
      end
      if (advance && s_vld) begin
         for (int i = 0; i < NbrMax; i++) begin
            if (s_keep[i]) q_mem[wr_ff + QAw'(i)] <= {CntW'(i + 1) == n_w, s_list[i]};
         end
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/lgni_mod.sv @@
// Layer phase unit: coord_z mod (hex_layers + prism_layers), one bit per stage.
// Uses lgni_pkg. Restoring division pipelined over the 10 quotient bits.
`default_nettype none
module lgni_mod (
   input wire logic clock,
   input wire logic reset,
   input wire logic advance,
   input wire logic in_valid,
   input wire logic [lgni_pkg::CoordW-1:0] in_z,
   input wire logic [lgni_pkg::SizeW-1:0] in_period,
   output logic [lgni_pkg::SizeW-1:0] out_rem
);
   import lgni_pkg::*;
   logic [CoordW:0][SizeW:0] rem_ff;
   logic [CoordW:0][CoordW-1:0] z_ff;
   logic [CoordW:0][SizeW-1:0] per_ff;
   logic [CoordW:0] vld_ff;
   logic [CoordW-1:0][SizeW:0] rem_in;

   always_comb begin
      for (int s = 0; s < CoordW; s++) begin
         logic [SizeW+1:0] t;
         t = {rem_ff[s], z_ff[s][CoordW-1-s]};
         if (t >= {1'b0, 1'b0, per_ff[s]}) t = t - {2'b0, per_ff[s]};
         rem_in[s] = t[SizeW:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) begin
         vld_ff <= {vld_ff[CoordW-1:0], in_valid};
      end
      if (advance) begin
         rem_ff[0] <= '0;
         z_ff[0] <= in_z;
         per_ff[0] <= in_period;
         for (int s = 0; s < CoordW; s++) begin
            rem_ff[s+1] <= rem_in[s];
            z_ff[s+1] <= z_ff[s];
            per_ff[s+1] <= per_ff[s];
         end
      end
   end

   assign out_rem = (per_ff[CoordW] == '0) ? {1'b0, z_ff[CoordW]}
                                           : rem_ff[CoordW][SizeW-1:0];
   logic unused_v;
   assign unused_v = ^{vld_ff, rem_ff[CoordW][SizeW]};
endmodule
`default_nettype wire

@@ rtl/core/lgni_sort.sv @@
// Sorting network stage: odd-even transposition over nine indices, one pass a stage.
// Uses lgni_pkg.
`default_nettype none
module lgni_sort (
   input wire logic clock,
   input wire logic reset,
   input wire logic advance,
   input wire logic in_valid,
   input wire lgni_pkg::idx_list_type in_list,
   input wire logic [lgni_pkg::NbrMax-1:0] in_keep,
   output logic out_valid,
   output lgni_pkg::idx_list_type out_list,
   output logic [lgni_pkg::NbrMax-1:0] out_keep
);
   import lgni_pkg::*;
   idx_list_type [NbrMax:0] list_ff;
   logic [NbrMax:0][NbrMax-1:0] keep_ff;
   logic [NbrMax:0] vld_ff;
   idx_list_type [NbrMax-1:0] list_in;
   logic [NbrMax-1:0][NbrMax-1:0] keep_in;

   always_comb begin
      for (int s = 0; s < NbrMax; s++) begin
         list_in[s] = list_ff[s];
         keep_in[s] = keep_ff[s];
         for (int p = s % 2; p + 1 < NbrMax; p += 2) begin
            // dropped entries sink to the top
            if ((!keep_ff[s][p] && keep_ff[s][p+1]) || (keep_ff[s][p] && keep_ff[s][p+1]
                  && list_ff[s][p] > list_ff[s][p+1])) begin
               list_in[s][p] = list_ff[s][p+1];
               list_in[s][p+1] = list_ff[s][p];
               keep_in[s][p] = keep_ff[s][p+1];
               keep_in[s][p+1] = keep_ff[s][p];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[NbrMax-1:0], in_valid};
      if (advance) begin
         list_ff[0] <= in_list;
         keep_ff[0] <= in_keep;
         for (int s = 0; s < NbrMax; s++) begin
            list_ff[s+1] <= list_in[s];
            keep_ff[s+1] <= keep_in[s];
         end
      end
   end

   assign out_valid = vld_ff[NbrMax];
   assign out_list = list_ff[NbrMax];
   assign out_keep = keep_ff[NbrMax];
endmodule
`default_nettype wire
